FILE: design/ple_pkg.sv
package ple_pkg;

    // Fixed field widths of the item channels.
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 5;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Opcodes carried by an input item.
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // Status codes carried by a result item.
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ELEMENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        t_value           value;
        logic [POS_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_value              value_out;
        logic [TOTAL_W-1:0]  entry_total;
        logic                last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic dump_step;
    } t_pl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic dump_last;
    } t_pl_status;

endpackage

FILE: design/ple_ctrl.sv
module ple_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [ple_pkg::OP_W-1:0]     i_opcode,
    input  ple_pkg::t_pl_status          i_status,
    output logic                         o_in_stall,
    output ple_pkg::t_pl_cmd             o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic r_state;
    logic n_state;

    // Commands: execute an item in idle, emit one element per free output slot in dump.
    always_comb begin
        o_cmd.exec      = 1'b0;
        o_cmd.dump_step = 1'b0;
        o_in_stall      = 1'b1;
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_opcode == ple_pkg::OP_DUMP && !i_status.count_zero) begin
                        n_state = S_DUMP;
                    end
                end
            end
            S_DUMP: begin
                if (i_status.out_free) begin
                    o_cmd.dump_step = 1'b1;
                    if (i_status.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/ple_datapath.sv
module ple_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ple_pkg::t_in_item    i_in_item,
    input  ple_pkg::t_pl_cmd     i_cmd,
    input  logic                 i_out_stall,
    output ple_pkg::t_pl_status  o_status,
    output logic                 o_out_valid,
    output ple_pkg::t_out_item   o_out_item
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    ple_pkg::t_value r_cell [CAPACITY];
    ple_pkg::t_value n_cell [CAPACITY];
    ple_pkg::t_value w_above [CAPACITY];
    ple_pkg::t_value w_below [CAPACITY];

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [IW-1:0]   r_idx;
    logic            r_out_valid;
    ple_pkg::t_out_item r_out_item;
    ple_pkg::t_out_item w_load_item;
    logic            w_load;

    logic [CMPW-1:0] w_count_ext;
    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_next_count_ext;
    logic            w_full;
    logic            w_app_we;
    logic            w_ins_we;
    logic            w_rem_we;
    logic            w_rot;
    logic            w_dump_last;

    assign w_count_ext = CMPW'(r_count);
    assign w_pos_ext   = CMPW'(i_in_item.position);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_rot       = i_cmd.dump_step;
    assign w_dump_last = ((CMPW'(r_idx) + CMPW'(1)) == w_count_ext);

    // Decode of an executed item or a dump step: list update and at most one result.
    always_comb begin
        w_app_we    = 1'b0;
        w_ins_we    = 1'b0;
        w_rem_we    = 1'b0;
        w_load      = 1'b0;
        n_count     = r_count;
        w_load_item.status      = ple_pkg::ST_DONE;
        w_load_item.value_out   = '0;
        w_load_item.last        = 1'b1;
        if (i_cmd.exec) begin
            w_load = 1'b1;
            unique case (i_in_item.opcode)
                ple_pkg::OP_APPEND: begin
                    if (w_full) begin
                        w_load_item.status = ple_pkg::ST_FULL;
                    end else begin
                        w_app_we = 1'b1;
                        n_count  = CW'(r_count + 1'b1);
                    end
                end
                ple_pkg::OP_INSERT: begin
                    if (r_count == '0 || w_pos_ext > w_count_ext) begin
                        w_load_item.status = ple_pkg::ST_REJECT;
                    end else if (w_full) begin
                        w_load_item.status = ple_pkg::ST_FULL;
                    end else begin
                        w_ins_we = 1'b1;
                        n_count  = CW'(r_count + 1'b1);
                    end
                end
                ple_pkg::OP_REMOVE: begin
                    if (w_pos_ext >= w_count_ext) begin
                        w_load_item.status = ple_pkg::ST_REJECT;
                    end else begin
                        w_rem_we = 1'b1;
                        n_count  = CW'(r_count - 1'b1);
                    end
                end
                ple_pkg::OP_DUMP: begin
                    // A non-empty list is emitted by the dump steps instead.
                    if (r_count == '0) begin
                        w_load_item.status = ple_pkg::ST_EMPTY;
                    end else begin
                        w_load = 1'b0;
                    end
                end
                ple_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.dump_step) begin
            w_load = 1'b1;
            w_load_item.status    = ple_pkg::ST_ELEMENT;
            w_load_item.value_out = r_cell[0];
            w_load_item.last      = w_dump_last;
        end
        // The total always reports the count after the operation.
        w_next_count_ext        = CMPW'(n_count);
        w_load_item.entry_total = w_next_count_ext[ple_pkg::TOTAL_W-1:0];
    end

    // Cell row: each cell picks from its neighbors, the input value or cell 0.
    // A dump rotates the first count cells down by one, so after count steps
    // the list is back in place.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam logic [CMPW-1:0] K  = CMPW'(gi);
            localparam logic [CMPW-1:0] K1 = CMPW'(gi + 1);

            if (gi < CAPACITY - 1) begin : g_up
                assign w_above[gi] = r_cell[gi + 1];
            end else begin : g_top
                assign w_above[gi] = r_cell[gi];
            end

            if (gi > 0) begin : g_dn
                assign w_below[gi] = r_cell[gi - 1];
            end else begin : g_bot
                assign w_below[gi] = r_cell[gi];
            end

            always_comb begin
                n_cell[gi] = r_cell[gi];
                if (w_ins_we) begin
                    if (K > w_pos_ext) begin
                        n_cell[gi] = w_below[gi];
                    end else if (K == w_pos_ext) begin
                        n_cell[gi] = i_in_item.value;
                    end
                end
                if (w_app_we && K == w_count_ext) begin
                    n_cell[gi] = i_in_item.value;
                end
                if (w_rem_we && K >= w_pos_ext) begin
                    n_cell[gi] = w_above[gi];
                end
                if (w_rot) begin
                    if (K1 == w_count_ext) begin
                        n_cell[gi] = r_cell[0];
                    end else if (K1 < w_count_ext) begin
                        n_cell[gi] = w_above[gi];
                    end
                end
            end
        end
    endgenerate

    // Cell storage holds no reset value; only cells below the count are read.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            r_cell[k] <= n_cell[k];
        end
    end

    // Count and dump index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.exec) begin
                r_idx <= '0;
            end else if (i_cmd.dump_step) begin
                r_idx <= IW'(r_idx + 1'b1);
            end
        end
    end

    // Output register: one result waits here while the next is prepared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= w_load_item;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out_item;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.dump_last  = w_dump_last;

    // The list never holds more entries than the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The controller never executes an item and steps a dump together.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && i_cmd.dump_step))
        else $error("execute and dump step together");

    // A dump step only reads entries that are in the list.
    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_step |-> (CMPW'(r_idx) < w_count_ext))
        else $error("dump index past the count");

    // A dump step always leaves a result in the output register.
    a_dump_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_step |=> r_out_valid)
        else $error("dump element lost");

endmodule

FILE: design/positional_list_engine_top.sv
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// entries held in a row of registers that shift in parallel. Append, insert,
// remove, clear and unknown opcodes each give a single registered result
// item, so such items can be accepted every cycle while the output keeps
// up. A dump of N entries gives N result items, one per cycle while the
// output is free, as the list rotates its first entry out; a dump of an
// empty list gives one item with the empty status. Input stalls during a
// dump and can be accepted again once the state is back in idle after the
// last element. A single output register separates the two sides, so a
// stall on the output holds the engine without losing any item. No memory
// clearing is needed after reset; the list starts empty.
module positional_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ple_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ple_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);

    ple_pkg::t_pl_cmd    w_cmd;
    ple_pkg::t_pl_status w_status;

    // Sequencing of items and dump steps.
    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // List cells, count and output register.
    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
